[rtl/z80pd_pkg.sv]
`default_nettype none
package z80pd_pkg;

    localparam logic [7:0] PFX_IX = 8'hDD;
    localparam logic [7:0] PFX_IY = 8'hFD;
    localparam logic [7:0] OP_ED  = 8'hED;
    localparam logic [7:0] OP_CB  = 8'hCB;

    typedef enum logic [2:0] {
        FLOW_NONE  = 3'd0,
        FLOW_JUMP  = 3'd1,
        FLOW_CJUMP = 3'd2,
        FLOW_CALL  = 3'd3,
        FLOW_CCALL = 3'd4,
        FLOW_RET   = 3'd5,
        FLOW_CRET  = 3'd6,
        FLOW_HALT  = 3'd7
    } flow_t;

    // Where the static target comes from.
    typedef enum logic [1:0] {
        TGT_NONE = 2'd0,
        TGT_WORD = 2'd1,
        TGT_REL  = 2'd2,
        TGT_RST  = 2'd3
    } tgt_sel_t;

    // Stage one result: prefix resolved, opcode and the two bytes after it.
    typedef struct packed {
        logic [15:0] addr;
        logic [7:0]  op;
        logic [7:0]  opnd0;
        logic [7:0]  opnd1;
        logic        pre;
        logic        idx;
        logic        dbl;
    } pfx_t;

    // Stage two result: length, flow and target selection.
    typedef struct packed {
        logic [15:0] addr;
        logic [2:0]  len;
        flow_t       flow;
        tgt_sel_t    tsel;
        logic [7:0]  opnd0;
        logic [7:0]  opnd1;
        logic [2:0]  rst_y;
        logic        bad;
    } dec_t;

endpackage
`default_nettype wire

[rtl/z80pd_prefix.sv]
`default_nettype none
module z80pd_prefix import z80pd_pkg::*; (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [15:0] instr_addr,
    input  wire logic [7:0]  byte_zero,
    input  wire logic [7:0]  byte_one,
    input  wire logic [7:0]  byte_two,
    input  wire logic [7:0]  byte_three,
    output logic             out_valid,
    input  wire logic        out_ready,
    output pfx_t             out_data
);

    logic valid_reg;
    pfx_t data_reg;
    pfx_t data_next;
    logic b0_pfx;
    logic b1_pfx;

    assign in_ready = !valid_reg || out_ready;

    always_comb begin
        b0_pfx = (byte_zero == PFX_IX) || (byte_zero == PFX_IY);
        b1_pfx = (byte_one == PFX_IX) || (byte_one == PFX_IY);
        data_next.addr  = instr_addr;
        data_next.dbl   = b0_pfx && b1_pfx;
        data_next.pre   = b0_pfx && !b1_pfx;
        // A prefix in front of ED is dropped and does not index anything.
        data_next.idx   = b0_pfx && !b1_pfx && (byte_one != OP_ED);
        data_next.op    = data_next.pre ? byte_one   : byte_zero;
        data_next.opnd0 = data_next.pre ? byte_two   : byte_one;
        data_next.opnd1 = data_next.pre ? byte_three : byte_two;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule
`default_nettype wire

[rtl/z80pd_decode.sv]
`default_nettype none
module z80pd_decode import z80pd_pkg::*; (
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic in_valid,
    output logic      in_ready,
    input  wire pfx_t in_data,
    output logic      out_valid,
    input  wire logic out_ready,
    output dec_t      out_data
);

    logic       valid_reg;
    dec_t       data_reg;
    dec_t       data_next;
    logic [1:0] x;
    logic [2:0] y;
    logic [2:0] z;
    logic [1:0] ex;
    logic [2:0] ey;
    logic [2:0] ez;
    logic [2:0] base;
    logic [1:0] ext;
    logic       r6y;
    logic       r6z;

    assign in_ready = !valid_reg || out_ready;

    always_comb begin
        x    = in_data.op[7:6];
        y    = in_data.op[5:3];
        z    = in_data.op[2:0];
        ex   = in_data.opnd0[7:6];
        ey   = in_data.opnd0[5:3];
        ez   = in_data.opnd0[2:0];
        base = in_data.pre ? 3'd2 : 3'd1;
        r6y  = in_data.idx && (y == 3'd6);
        r6z  = in_data.idx && (z == 3'd6);
        ext  = 2'd0;

        data_next.addr  = in_data.addr;
        data_next.opnd0 = in_data.opnd0;
        data_next.opnd1 = in_data.opnd1;
        data_next.rst_y = y;
        data_next.flow  = FLOW_NONE;
        data_next.tsel  = TGT_NONE;
        data_next.bad   = 1'b0;
        data_next.len   = base;

        if (in_data.dbl) begin
            data_next.len = 3'd1;
            data_next.bad = 1'b1;
        end else if (in_data.op == OP_ED) begin
            ext = 2'd1;
            case (ex)
                2'd1: begin
                    if (ez == 3'd3) begin
                        ext = 2'd3;
                    end else if (ez == 3'd5) begin
                        data_next.flow = FLOW_RET;
                    end else if (ez == 3'd7 && ey >= 3'd6) begin
                        data_next.bad = 1'b1;
                    end
                end
                2'd2: begin
                    data_next.bad = !(ez <= 3'd3 && ey >= 3'd4);
                end
                default: begin
                    data_next.bad = 1'b1;
                end
            endcase
            data_next.len = base + {1'b0, ext};
        end else if (in_data.op == OP_CB) begin
            data_next.len = base + (in_data.idx ? 3'd2 : 3'd1);
        end else begin
            case (x)
                2'd0: begin
                    case (z)
                        3'd0: begin
                            if (y >= 3'd2) begin
                                ext            = 2'd1;
                                data_next.tsel = TGT_REL;
                                data_next.flow = (y == 3'd3) ? FLOW_JUMP : FLOW_CJUMP;
                            end
                        end
                        3'd1: ext = y[0] ? 2'd0 : 2'd2;
                        3'd2: ext = (y >= 3'd4) ? 2'd2 : 2'd0;
                        3'd4, 3'd5: ext = {1'b0, r6y};
                        3'd6: ext = r6y ? 2'd2 : 2'd1;
                        default: ext = 2'd0;
                    endcase
                end
                2'd1: begin
                    if (y == 3'd6 && z == 3'd6) begin
                        data_next.flow = FLOW_HALT;
                    end else begin
                        ext = {1'b0, r6y || r6z};
                    end
                end
                2'd2: ext = {1'b0, r6z};
                default: begin
                    case (z)
                        3'd0: data_next.flow = FLOW_CRET;
                        3'd1: begin
                            if (y == 3'd1) begin
                                data_next.flow = FLOW_RET;
                            end else if (y == 3'd5) begin
                                // Indirect jump through HL, IX or IY.
                                data_next.flow = FLOW_JUMP;
                            end
                        end
                        3'd2: begin
                            ext            = 2'd2;
                            data_next.flow = FLOW_CJUMP;
                            data_next.tsel = TGT_WORD;
                        end
                        3'd3: begin
                            if (y == 3'd0) begin
                                ext            = 2'd2;
                                data_next.flow = FLOW_JUMP;
                                data_next.tsel = TGT_WORD;
                            end else if (y == 3'd2 || y == 3'd3) begin
                                ext = 2'd1;
                            end
                        end
                        3'd4: begin
                            ext            = 2'd2;
                            data_next.flow = FLOW_CCALL;
                            data_next.tsel = TGT_WORD;
                        end
                        3'd5: begin
                            if (y[0]) begin
                                ext            = 2'd2;
                                data_next.flow = FLOW_CALL;
                                data_next.tsel = TGT_WORD;
                            end
                        end
                        3'd6: ext = 2'd1;
                        default: begin
                            data_next.flow = FLOW_CALL;
                            data_next.tsel = TGT_RST;
                        end
                    endcase
                end
            endcase
            data_next.len = base + {1'b0, ext};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule
`default_nettype wire

[rtl/z80pd_target.sv]
`default_nettype none
module z80pd_target import z80pd_pkg::*; (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire dec_t        in_data,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [2:0]       instr_length,
    output logic [2:0]       flow_kind,
    output logic             has_target,
    output logic [15:0]      target_addr,
    output logic             illegal
);

    logic        valid_reg;
    logic [2:0]  len_reg;
    logic [2:0]  flow_reg;
    logic        has_tgt_reg;
    logic [15:0] tgt_reg;
    logic        bad_reg;
    logic [15:0] tgt_next;

    assign in_ready = !valid_reg || out_ready;

    // Relative targets count from the end of the instruction.
    always_comb begin
        case (in_data.tsel)
            TGT_WORD: tgt_next = {in_data.opnd1, in_data.opnd0};
            TGT_REL:  tgt_next = in_data.addr + {13'd0, in_data.len}
                                 + {{8{in_data.opnd0[7]}}, in_data.opnd0};
            TGT_RST:  tgt_next = {10'd0, in_data.rst_y, 3'd0};
            default:  tgt_next = 16'd0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            len_reg     <= in_data.len;
            flow_reg    <= in_data.flow;
            has_tgt_reg <= (in_data.tsel != TGT_NONE);
            tgt_reg     <= tgt_next;
            bad_reg     <= in_data.bad;
        end
    end

    assign out_valid    = valid_reg;
    assign instr_length = len_reg;
    assign flow_kind    = flow_reg;
    assign has_target   = has_tgt_reg;
    assign target_addr  = tgt_reg;
    assign illegal      = bad_reg;

endmodule
`default_nettype wire

[rtl/z80_instruction_predecoder.sv]
`default_nettype none
// Z80 instruction predecoder. Each input word carries an instruction address
// and the five memory bytes starting there; each output word gives the
// instruction's length, its control-flow kind, the static branch or call
// target when one is known, and an illegal flag for a doubled DD/FD prefix
// or an undefined ED opcode. The block is a three-stage pipeline: the first
// stage resolves the index prefix, the second decodes length and flow kind,
// and the third forms the target, adding the displacement of relative jumps
// to the address after the instruction. A new word is taken in every cycle
// while the output is not stalled, and a result passes the prefix, decode
// and target registers in turn. Back-pressure on the output freezes only the
// stages that hold data, so empty stages keep filling while the result waits.
module z80_instruction_predecoder import z80pd_pkg::*; (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // instr_addr, byte_zero, byte_one, byte_two, byte_three, byte_four
    input  wire logic [55:0] s_tdata,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // instr_length, flow_kind, has_target, target_addr, illegal
    output logic [23:0]      m_tdata
);

    logic        pfx_valid;
    logic        pfx_ready;
    pfx_t        pfx_data;
    logic        dec_valid;
    logic        dec_ready;
    dec_t        dec_data;
    logic [2:0]  instr_length;
    logic [2:0]  flow_kind;
    logic        has_target;
    logic [15:0] target_addr;
    logic        illegal;

    // Stage one. The last window byte is never needed to decide the length,
    // flow kind or target of an instruction, so it is not carried.
    z80pd_prefix u_prefix (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .instr_addr (s_tdata[15:0]),
        .byte_zero  (s_tdata[23:16]),
        .byte_one   (s_tdata[31:24]),
        .byte_two   (s_tdata[39:32]),
        .byte_three (s_tdata[47:40]),
        .out_valid  (pfx_valid),
        .out_ready  (pfx_ready),
        .out_data   (pfx_data)
    );

    // Stage two: opcode tables for the main, ED and CB groups.
    z80pd_decode u_decode (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (pfx_valid),
        .in_ready  (pfx_ready),
        .in_data   (pfx_data),
        .out_valid (dec_valid),
        .out_ready (dec_ready),
        .out_data  (dec_data)
    );

    // Stage three: target formation and the output register.
    z80pd_target u_target (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .in_valid     (dec_valid),
        .in_ready     (dec_ready),
        .in_data      (dec_data),
        .out_valid    (m_tvalid),
        .out_ready    (m_tready),
        .instr_length (instr_length),
        .flow_kind    (flow_kind),
        .has_target   (has_target),
        .target_addr  (target_addr),
        .illegal      (illegal)
    );

    assign m_tdata = {illegal, target_addr, has_target, flow_kind, instr_length};

endmodule
`default_nettype wire

[sim/z80_instruction_predecoder_test.sv]
`timescale 1ns / 1ps
module z80_instruction_predecoder_test;
    import z80pd_pkg::*;

    localparam int STALL_LIMIT  = 2000;
    localparam int DRAIN_CYCLES = 8;

    // Opcodes used by the directed windows.
    localparam logic [7:0] OPC_NOP      = 8'h00;
    localparam logic [7:0] OPC_DJNZ     = 8'h10;
    localparam logic [7:0] OPC_JR       = 8'h18;
    localparam logic [7:0] OPC_JR_C     = 8'h38;
    localparam logic [7:0] OPC_LD_IND_N = 8'h36;
    localparam logic [7:0] OPC_HALT     = 8'h76;
    localparam logic [7:0] OPC_LD_A_IND = 8'h7E;
    localparam logic [7:0] OPC_JP       = 8'hC3;
    localparam logic [7:0] OPC_RET      = 8'hC9;
    localparam logic [7:0] OPC_JP_Z     = 8'hCA;
    localparam logic [7:0] OPC_CALL     = 8'hCD;
    localparam logic [7:0] OPC_CALL_NC  = 8'hD4;
    localparam logic [7:0] OPC_RET_PE   = 8'hE8;
    localparam logic [7:0] OPC_JP_HL    = 8'hE9;
    localparam logic [7:0] OPC_RST_38   = 8'hFF;
    localparam logic [7:0] OPC_SET_0_HL = 8'hC6;
    localparam logic [7:0] EXT_UNDEF_LO = 8'h00;
    localparam logic [7:0] EXT_LD_NN_BC = 8'h43;
    localparam logic [7:0] EXT_RETI     = 8'h4D;
    localparam logic [7:0] EXT_UNDEF_7F = 8'h7F;
    localparam logic [7:0] EXT_LDIR     = 8'hB0;

    // Decoded view of one instruction, laid out exactly like m_tdata.
    typedef struct packed {
        logic        bad;
        logic [15:0] tgt;
        logic        has_tgt;
        flow_t       flow;
        logic [2:0]  len;
    } insn_info_t;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [55:0] s_tdata  = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;

    // When set, neither side inserts idle cycles.
    logic        steady = 1'b0;

    insn_info_t  pending_decodes[$];
    insn_info_t  got_info;
    insn_info_t  want_info;
    int          mismatch_count = 0;
    int          words_sent     = 0;
    int          words_checked  = 0;
    int          illegal_seen   = 0;
    int          targets_seen   = 0;
    int          stall_cycles   = 0;

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    z80_instruction_predecoder u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // Window bytes past the fifth one read as zero.
    function automatic logic [7:0] window_byte(input logic [39:0] win, input logic [3:0] idx);
        if (idx < 4'd5) begin
            return win[idx*8 +: 8];
        end
        return 8'h00;
    endfunction

    // Instruction length, flow kind, static target and illegal flag for one
    // window. The position counter walks the window as bytes are consumed.
    function automatic insn_info_t predecode_window(input logic [15:0] addr,
                                                    input logic [39:0] win);
        insn_info_t  info;
        logic [3:0]  pos;
        logic        indexed;
        logic [7:0]  op;
        logic [7:0]  disp;
        logic [15:0] imm;
        logic [1:0]  x;
        logic [2:0]  y;
        logic [2:0]  z;
        info    = '0;
        pos     = 4'd1;
        indexed = 1'b0;
        op      = win[7:0];
        if (op == PFX_IX || op == PFX_IY) begin
            if (win[15:8] == PFX_IX || win[15:8] == PFX_IY) begin
                // A doubled prefix drops the first byte as illegal.
                info.bad = 1'b1;
            end else begin
                // A prefix in front of ED has no effect but still takes a byte.
                indexed = (win[15:8] != OP_ED);
                op      = win[15:8];
                pos     = 4'd2;
            end
        end
        x = op[7:6];
        y = op[5:3];
        z = op[2:0];
        if (info.bad) begin
            info.len = 3'd1;
        end else if (op == OP_ED) begin
            op  = window_byte(win, pos);
            pos = pos + 4'd1;
            x   = op[7:6];
            y   = op[5:3];
            z   = op[2:0];
            if (x == 2'd1) begin
                if (z == 3'd3) begin
                    pos = pos + 4'd2;
                end else if (z == 3'd5) begin
                    info.flow = FLOW_RET;
                end else if (z == 3'd7 && y >= 3'd6) begin
                    info.bad = 1'b1;
                end
            end else if (!(x == 2'd2 && z <= 3'd3 && y >= 3'd4)) begin
                info.bad = 1'b1;
            end
        end else if (op == OP_CB) begin
            // The indexed form carries a displacement ahead of the operation.
            pos = pos + (indexed ? 4'd2 : 4'd1);
        end else if (x == 2'd0) begin
            case (z)
                3'd0: begin
                    if (y >= 3'd2) begin
                        disp         = window_byte(win, pos);
                        pos          = pos + 4'd1;
                        info.flow    = (y == 3'd3) ? FLOW_JUMP : FLOW_CJUMP;
                        info.has_tgt = 1'b1;
                        info.tgt     = addr + {12'd0, pos} + {{8{disp[7]}}, disp};
                    end
                end
                3'd1: begin
                    if (!y[0]) pos = pos + 4'd2;
                end
                3'd2: begin
                    if (y >= 3'd4) pos = pos + 4'd2;
                end
                3'd4, 3'd5: begin
                    if (indexed && y == 3'd6) pos = pos + 4'd1;
                end
                3'd6: begin
                    pos = pos + ((indexed && y == 3'd6) ? 4'd2 : 4'd1);
                end
                default: ;
            endcase
        end else if (x == 2'd1) begin
            if (y == 3'd6 && z == 3'd6) begin
                info.flow = FLOW_HALT;
            end else if (indexed && (y == 3'd6 || z == 3'd6)) begin
                pos = pos + 4'd1;
            end
        end else if (x == 2'd2) begin
            if (indexed && z == 3'd6) pos = pos + 4'd1;
        end else begin
            imm = {window_byte(win, pos + 4'd1), window_byte(win, pos)};
            case (z)
                3'd0: info.flow = FLOW_CRET;
                3'd1: begin
                    if (y[0] && y[2:1] == 2'd0) begin
                        info.flow = FLOW_RET;
                    end else if (y[0] && y[2:1] == 2'd2) begin
                        // Register-indirect jump: the target is not static.
                        info.flow = FLOW_JUMP;
                    end
                end
                3'd2: begin
                    info.flow    = FLOW_CJUMP;
                    info.has_tgt = 1'b1;
                    info.tgt     = imm;
                    pos          = pos + 4'd2;
                end
                3'd3: begin
                    if (y == 3'd0) begin
                        info.flow    = FLOW_JUMP;
                        info.has_tgt = 1'b1;
                        info.tgt     = imm;
                        pos          = pos + 4'd2;
                    end else if (y == 3'd2 || y == 3'd3) begin
                        pos = pos + 4'd1;
                    end
                end
                3'd4: begin
                    info.flow    = FLOW_CCALL;
                    info.has_tgt = 1'b1;
                    info.tgt     = imm;
                    pos          = pos + 4'd2;
                end
                3'd5: begin
                    if (y[0]) begin
                        info.flow    = FLOW_CALL;
                        info.has_tgt = 1'b1;
                        info.tgt     = imm;
                        pos          = pos + 4'd2;
                    end
                end
                3'd6: pos = pos + 4'd1;
                default: begin
                    // Restart vectors sit at multiples of eight in page zero.
                    info.flow    = FLOW_CALL;
                    info.has_tgt = 1'b1;
                    info.tgt     = {10'd0, y, 3'd0};
                end
            endcase
        end
        info.len = pos[2:0];
        return info;
    endfunction

    // Sends one window, idling first at random, and records the decode that
    // must come back for it once the word has been accepted.
    task automatic send_window(input logic [15:0] addr, input logic [7:0] b0,
                               input logic [7:0] b1, input logic [7:0] b2,
                               input logic [7:0] b3, input logic [7:0] b4);
        logic [39:0] win;
        win = {b4, b3, b2, b1, b0};
        if (!steady && $urandom_range(99) < 29) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
            while ($urandom_range(99) < 29) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {win, addr};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        pending_decodes.push_back(predecode_window(addr, win));
        words_sent++;
    endtask

    task automatic wait_for_drain();
        while (pending_decodes.size() != 0) @(posedge aclk);
    endtask

    // Field extremes, every flow kind, prefix corner cases and target wrap.
    task automatic test_directed();
        send_window(16'h0000, OPC_NOP, 8'h00, 8'h00, 8'h00, 8'h00);
        send_window(16'hFFFF, OPC_RST_38, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
        send_window(16'h1234, OPC_HALT, 8'h00, 8'h00, 8'h00, 8'h00);
        // Relative targets wrapping past the top and the bottom of memory.
        send_window(16'hFFFE, OPC_JR, 8'h7F, 8'h00, 8'h00, 8'h00);
        send_window(16'h0001, OPC_DJNZ, 8'h80, 8'h00, 8'h00, 8'h00);
        send_window(16'h8000, OPC_JR_C, 8'hFE, 8'h00, 8'h00, 8'h00);
        send_window(16'h4000, OPC_JP, 8'h34, 8'h12, 8'h00, 8'h00);
        send_window(16'h4000, OPC_JP_Z, 8'hFF, 8'hFF, 8'h00, 8'h00);
        send_window(16'h0100, OPC_CALL, 8'h00, 8'h80, 8'h00, 8'h00);
        send_window(16'h0100, OPC_CALL_NC, 8'h01, 8'h00, 8'h00, 8'h00);
        send_window(16'h2000, OPC_RET, 8'h00, 8'h00, 8'h00, 8'h00);
        send_window(16'h2000, OPC_RET_PE, 8'h00, 8'h00, 8'h00, 8'h00);
        send_window(16'h3000, OPC_JP_HL, 8'h00, 8'h00, 8'h00, 8'h00);
        send_window(16'h3000, PFX_IX, OPC_JP_HL, 8'h00, 8'h00, 8'h00);
        // Doubled prefixes: the same prefix twice and a mixed pair.
        send_window(16'h5000, PFX_IX, PFX_IX, 8'h00, 8'h00, 8'h00);
        send_window(16'h5000, PFX_IY, PFX_IX, 8'h00, 8'h00, 8'h00);
        // Index prefix ahead of the extended group is skipped.
        send_window(16'h6000, PFX_IX, OP_ED, EXT_RETI, 8'h00, 8'h00);
        send_window(16'h6000, OP_ED, EXT_UNDEF_LO, 8'h00, 8'h00, 8'h00);
        send_window(16'h6000, PFX_IY, OP_ED, EXT_UNDEF_LO, 8'h00, 8'h00);
        send_window(16'h6000, OP_ED, EXT_UNDEF_7F, 8'h00, 8'h00, 8'h00);
        send_window(16'h6000, OP_ED, EXT_LDIR, 8'h00, 8'h00, 8'h00);
        send_window(16'h7000, OP_ED, EXT_LD_NN_BC, 8'h34, 8'h12, 8'h00);
        send_window(16'h7000, PFX_IY, OP_ED, EXT_LD_NN_BC, 8'h34, 8'h12);
        // Indexed bit group, indexed store of an immediate, indexed load, indexed HALT.
        send_window(16'h9000, PFX_IX, OP_CB, 8'h05, OPC_SET_0_HL, 8'h00);
        send_window(16'h9000, PFX_IY, OPC_LD_IND_N, 8'h05, 8'hAA, 8'h00);
        send_window(16'h9000, PFX_IX, OPC_LD_A_IND, 8'h05, 8'h00, 8'h00);
        send_window(16'h9000, PFX_IX, OPC_HALT, 8'h00, 8'h00, 8'h00);
    endtask

    // Fully random windows; the middle stretch runs with no idling at all.
    task automatic test_random_windows(input int count);
        for (int i = 0; i < count; i++) begin
            steady = (i >= count / 3 && i < 2 * count / 3);
            send_window(16'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                        8'($urandom), 8'($urandom));
        end
        steady = 1'b0;
    endtask

    function automatic logic [7:0] prefix_heavy_byte();
        case ($urandom_range(7))
            0: return PFX_IX;
            1: return PFX_IY;
            2: return OP_ED;
            3: return OP_CB;
            default: return 8'($urandom);
        endcase
    endfunction

    // Windows dense in prefixes and group escapes, so that the prefixed,
    // extended and bit groups are reached far more often than by chance.
    task automatic test_prefixed_windows(input int count);
        for (int i = 0; i < count; i++) begin
            send_window(16'($urandom), prefix_heavy_byte(), prefix_heavy_byte(),
                        8'($urandom), 8'($urandom), 8'($urandom));
        end
    endtask

    // Control-flow opcodes with extreme displacements near the address ends.
    task automatic test_branch_windows(input int count);
        logic [15:0] addr;
        logic [7:0]  op;
        logic [7:0]  disp;
        logic [2:0]  y;
        logic [2:0]  z;
        for (int i = 0; i < count; i++) begin
            y = 3'($urandom);
            z = 3'($urandom);
            op = $urandom_range(1) ? {2'b00, y, 3'b000} : {2'b11, y, z};
            case ($urandom_range(3))
                0: disp = 8'h80;
                1: disp = 8'h7F;
                default: disp = 8'($urandom);
            endcase
            case ($urandom_range(2))
                0: addr = 16'hFFFF - 16'($urandom_range(7));
                1: addr = 16'($urandom_range(7));
                default: addr = 16'($urandom);
            endcase
            if ($urandom_range(3) == 0) begin
                send_window(addr, $urandom_range(1) ? PFX_IX : PFX_IY, op, disp,
                            8'($urandom), 8'($urandom));
            end else begin
                send_window(addr, op, disp, 8'($urandom), 8'($urandom), 8'($urandom));
            end
        end
    endtask

    // The sender holds off until every outstanding result has come back.
    task automatic test_drain_pause();
        for (int i = 0; i < 20; i++) begin
            send_window(16'($urandom), prefix_heavy_byte(), 8'($urandom), 8'($urandom),
                        8'($urandom), 8'($urandom));
        end
        s_tvalid <= 1'b0;
        wait_for_drain();
        for (int i = 0; i < 20; i++) begin
            send_window(16'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                        8'($urandom), 8'($urandom));
        end
    endtask

    // The result side stalls at random except while the sender runs steady.
    always @(posedge aclk) begin
        m_tready <= steady || ($urandom_range(99) >= 29);
    end

    // Every accepted result is matched against the oldest outstanding decode.
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            got_info = m_tdata;
            if (pending_decodes.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10) begin
                    $display("ERROR: result word %h arrived with nothing outstanding",
                             m_tdata);
                end
            end else begin
                want_info = pending_decodes.pop_front();
                words_checked++;
                if (want_info.bad) illegal_seen++;
                if (want_info.has_tgt) targets_seen++;
                if (got_info.len !== want_info.len || got_info.flow !== want_info.flow ||
                    got_info.has_tgt !== want_info.has_tgt ||
                    got_info.tgt !== want_info.tgt || got_info.bad !== want_info.bad) begin
                    mismatch_count++;
                    if (mismatch_count <= 10) begin
                        $display("ERROR: result %0d: expected len %0d flow %0d tgt %0b/%h bad %0b",
                                 words_checked, want_info.len, want_info.flow,
                                 want_info.has_tgt, want_info.tgt, want_info.bad);
                        $display("       got len %0d flow %0d tgt %0b/%h bad %0b",
                                 got_info.len, got_info.flow, got_info.has_tgt,
                                 got_info.tgt, got_info.bad);
                    end
                end
            end
        end
    end

    // The run ends when too many cycles go by without any word moving.
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
        if (stall_cycles == STALL_LIMIT) begin
            $display("ERROR: no word moved for %0d cycles", STALL_LIMIT);
            $display("Regression FAIL");
            $finish;
        end
    end

    initial begin
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed();
        test_random_windows(450);
        test_prefixed_windows(400);
        test_branch_windows(300);
        test_drain_pause();
        s_tvalid <= 1'b0;
        wait_for_drain();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        // Words still outstanding at the end count as failures too.
        mismatch_count += pending_decodes.size();
        $display("Sent %0d windows and checked %0d results, %0d mismatches.",
                 words_sent, words_checked, mismatch_count);
        $display("Results included %0d illegal encodings and %0d static targets.",
                 illegal_seen, targets_seen);
        if (mismatch_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
